/* rtl/core/mfr_pkg.sv */
// Shared types, codes and decode functions of the Manchester frame receiver.
package mfr_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_CORRUPT  = 3'd2;
	localparam logic [2:0] ST_DEST     = 3'd3;
	localparam logic [2:0] ST_SOURCE   = 3'd4;
	localparam logic [2:0] ST_CHECKSUM = 3'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [1:0] REG_OWN_ADDRESS  = 2'd0;
	localparam logic [1:0] REG_PEER_ADDRESS = 2'd1;
	localparam logic [1:0] REG_HUNT_LIMIT   = 2'd2;

	localparam logic [7:0] HUNT_LIMIT_RESET = 8'd10;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload;
		logic [2:0] status;
		logic [7:0] length;
	} mfr_result_t;

	// Each pair contributes (pair - 1); the lowest pair carries the most weight.
	// The sum wraps at 8 bits, so pairs 00 and 11 fold in as -1 and +2.
	function automatic logic [7:0] decode_half(input logic [7:0] b);
		logic [7:0] v;
		v = {3'b000, b[1:0], 3'b000} + {4'b0000, b[3:2], 2'b00}
			+ {5'b00000, b[5:4], 1'b0} + {6'b000000, b[7:6]} - 8'd15;
		return v;
	endfunction

	// A byte is valid when every pair is 01 or 10.
	function automatic logic pairs_valid(input logic [7:0] b);
		return (b[7] ^ b[6]) & (b[5] ^ b[4]) & (b[3] ^ b[2]) & (b[1] ^ b[0]);
	endfunction

endpackage

/* rtl/core/manchester_frame_receiver_unit.sv */
// Top level of the Manchester frame receiver: byte decode, frame sequencer and result buffer.
// The receiver takes one Manchester-coded UART byte per beat and can accept a beat in every
// clock cycle. Two bytes form one frame byte (high half first). A frame is destination,
// source, length, payload and an 8-bit additive checksum; each payload byte gives one
// payload result and the frame closes with one status result, as do timeout and errors.
// All decode, compare and sum logic for a beat sits between the frame state registers and
// a two-entry result buffer, so a result is buffered at the edge that takes its beat; input
// beats keep flowing while one result waits for the consumer; in_ready drops only when
// both buffer entries are full. The APB registers (own_address at 0x0, peer_address at
// 0x4, hunt_limit at 0x8) take effect at once and should be written while the block idles.
module manchester_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  end_status,
	output logic [7:0]  received_length
);

	localparam logic [3:0] PH_HUNT   = 4'd0;
	localparam logic [3:0] PH_DST_LO = 4'd1;
	localparam logic [3:0] PH_SRC_HI = 4'd2;
	localparam logic [3:0] PH_SRC_LO = 4'd3;
	localparam logic [3:0] PH_LEN_HI = 4'd4;
	localparam logic [3:0] PH_LEN_LO = 4'd5;
	localparam logic [3:0] PH_PAY_HI = 4'd6;
	localparam logic [3:0] PH_PAY_LO = 4'd7;
	localparam logic [3:0] PH_SUM_HI = 4'd8;
	localparam logic [3:0] PH_SUM_LO = 4'd9;

	logic [7:0] own_address_q;
	logic [7:0] peer_address_q;
	logic [7:0] hunt_limit_q;

	logic [3:0] frame_phase_q;
	logic [7:0] hunt_count_q;
	logic [7:0] high_half_q;
	logic [7:0] running_sum_q;
	logic [7:0] expected_length_q;
	logic [7:0] bytes_seen_q;

	logic [3:0] frame_phase_d;
	logic [7:0] hunt_count_d;
	logic [7:0] high_half_d;
	logic [7:0] running_sum_d;
	logic [7:0] expected_length_d;
	logic [7:0] bytes_seen_d;

	logic                 main_valid_q;
	logic                 skid_valid_q;
	mfr_pkg::mfr_result_t main_q;
	mfr_pkg::mfr_result_t skid_q;

	logic                 res_valid;
	mfr_pkg::mfr_result_t res;

	logic       accept;
	logic       pop;
	logic       push;
	logic       cfg_write;
	logic [7:0] half;
	logic [7:0] full;
	logic [7:0] count_inc;
	logic [7:0] seen_inc;
	logic       byte_ok;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign in_ready  = ~skid_valid_q;
	assign accept    = in_valid & in_ready;
	assign pop       = main_valid_q & out_ready;
	assign push      = accept & res_valid;

	assign half      = mfr_pkg::decode_half(rx_byte);
	assign full      = {high_half_q[3:0], 4'b0000} + half;
	assign byte_ok   = mfr_pkg::pairs_valid(rx_byte);
	assign count_inc = hunt_count_q + 8'd1;
	assign seen_inc  = bytes_seen_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q  <= '0;
			peer_address_q <= '0;
			hunt_limit_q   <= mfr_pkg::HUNT_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				mfr_pkg::REG_OWN_ADDRESS:  own_address_q  <= pwdata[7:0];
				mfr_pkg::REG_PEER_ADDRESS: peer_address_q <= pwdata[7:0];
				mfr_pkg::REG_HUNT_LIMIT:   hunt_limit_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mfr_pkg::REG_OWN_ADDRESS:  prdata = {24'd0, own_address_q};
			mfr_pkg::REG_PEER_ADDRESS: prdata = {24'd0, peer_address_q};
			mfr_pkg::REG_HUNT_LIMIT:   prdata = {24'd0, hunt_limit_q};
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		frame_phase_d     = frame_phase_q;
		hunt_count_d      = hunt_count_q;
		high_half_d       = high_half_q;
		running_sum_d     = running_sum_q;
		expected_length_d = expected_length_q;
		bytes_seen_d      = bytes_seen_q;
		res_valid         = 1'b0;
		res.kind          = mfr_pkg::KIND_STATUS;
		res.payload       = '0;
		res.status        = mfr_pkg::ST_OK;
		res.length        = '0;

		unique case (frame_phase_q)
			PH_HUNT: begin
				if (count_inc > hunt_limit_q) begin
					res_valid  = 1'b1;
					res.status = mfr_pkg::ST_TIMEOUT;
				end else begin
					hunt_count_d = count_inc;
					if (byte_ok) begin
						high_half_d   = half;
						frame_phase_d = PH_DST_LO;
					end
				end
			end
			PH_DST_LO: begin
				if (!byte_ok) begin
					res_valid  = 1'b1;
					res.status = mfr_pkg::ST_CORRUPT;
				end else if (full != own_address_q) begin
					res_valid  = 1'b1;
					res.status = mfr_pkg::ST_DEST;
				end else begin
					running_sum_d = full;
					frame_phase_d = PH_SRC_HI;
				end
			end
			PH_SRC_HI, PH_LEN_HI, PH_PAY_HI, PH_SUM_HI: begin
				high_half_d   = half;
				frame_phase_d = frame_phase_q + 4'd1;
			end
			PH_SRC_LO: begin
				if (full != peer_address_q) begin
					res_valid  = 1'b1;
					res.status = mfr_pkg::ST_SOURCE;
				end else begin
					running_sum_d = running_sum_q + full;
					frame_phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_LO: begin
				running_sum_d     = running_sum_q + full;
				expected_length_d = full;
				bytes_seen_d      = '0;
				frame_phase_d     = (full == 8'd0) ? PH_SUM_HI : PH_PAY_HI;
			end
			PH_PAY_LO: begin
				running_sum_d = running_sum_q + full;
				bytes_seen_d  = seen_inc;
				frame_phase_d = (seen_inc == expected_length_q) ? PH_SUM_HI : PH_PAY_HI;
				res_valid     = 1'b1;
				res.kind      = mfr_pkg::KIND_PAYLOAD;
				res.payload   = full;
			end
			PH_SUM_LO: begin
				res_valid = 1'b1;
				if (full != running_sum_q) begin
					res.status = mfr_pkg::ST_CHECKSUM;
				end else begin
					res.length = expected_length_q;
				end
			end
			default: begin
				frame_phase_d = PH_HUNT;
				hunt_count_d  = '0;
			end
		endcase

		// Every status result sends the sequencer back to hunting with a fresh count.
		if (res_valid && res.kind == mfr_pkg::KIND_STATUS) begin
			frame_phase_d = PH_HUNT;
			hunt_count_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase_q     <= PH_HUNT;
			hunt_count_q      <= '0;
			high_half_q       <= '0;
			running_sum_q     <= '0;
			expected_length_q <= '0;
			bytes_seen_q      <= '0;
		end else if (accept) begin
			frame_phase_q     <= frame_phase_d;
			hunt_count_q      <= hunt_count_d;
			high_half_q       <= high_half_d;
			running_sum_q     <= running_sum_d;
			expected_length_q <= expected_length_d;
			bytes_seen_q      <= bytes_seen_d;
		end
	end

	// Two-entry result buffer; the skid entry only fills while the main entry is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= res;
			end else begin
				main_q <= res;
			end
		end
	end

	assign out_valid       = main_valid_q;
	assign result_kind     = main_q.kind;
	assign payload_byte    = main_q.payload;
	assign end_status      = main_q.status;
	assign received_length = main_q.length;

endmodule

/* sim/manchester_frame_receiver_unit_tb.sv */
// Self-checking testbench for the Manchester frame receiver: directed frame table, then random traffic.
`timescale 1ns / 1ps

module manchester_frame_receiver_unit_tb;

	localparam int STALL_LIMIT = 2000;

	typedef enum logic [3:0] {
		PH_HUNT, PH_DST_LO, PH_SRC_HI, PH_SRC_LO, PH_LEN_HI,
		PH_LEN_LO, PH_PAY_HI, PH_PAY_LO, PH_SUM_HI, PH_SUM_LO
	} frame_phase_t;

	typedef struct packed {
		logic [7:0]           rx;
		logic                 fixed;
		logic                 has;
		mfr_pkg::mfr_result_t res;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] own;
		logic [7:0] peer;
		logic [7:0] limit;
		int         idle;
		int         budget;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [2:0]  end_status;
	logic [7:0]  received_length;

	// Predictor copy of the registers and of the frame state.
	logic [7:0]   own_addr_cfg = 8'h00;
	logic [7:0]   peer_addr_cfg = 8'h00;
	logic [7:0]   hunt_limit_cfg = mfr_pkg::HUNT_LIMIT_RESET;
	frame_phase_t phase_q = PH_HUNT;
	logic [7:0]   hunt_cnt = '0;
	logic [7:0]   hi_half = '0;
	logic [7:0]   run_sum = '0;
	logic [7:0]   frame_len = '0;
	logic [7:0]   pay_cnt = '0;

	mfr_pkg::mfr_result_t results_due[$];
	int                   errors = 0;
	int                   beats_sent = 0;
	int                   in_idle_pct = 21;
	int                   out_stall_pct = 21;

	manchester_frame_receiver_unit u_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] unpack_half(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		for (int k = 0; k < 4; k++) begin
			v = v + {6'd0, b[2*k +: 2]} - 8'd1;
			if (k < 3)
				v = v << 1;
		end
		return v;
	endfunction

	function automatic logic clean_pairs(input logic [7:0] b);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++)
			if (b[2*k +: 2] == 2'b00 || b[2*k +: 2] == 2'b11)
				ok = 1'b0;
		return ok;
	endfunction

	// The lowest pair carries the top bit of the half.
	function automatic logic [7:0] enc_half(input logic [3:0] n);
		logic [7:0] b;
		for (int k = 0; k < 4; k++)
			b[2*k +: 2] = n[3-k] ? 2'b10 : 2'b01;
		return b;
	endfunction

	function automatic logic [7:0] bad_byte();
		logic [7:0] b;
		int k;
		b = 8'($urandom_range(255));
		k = $urandom_range(3);
		b[2*k +: 2] = $urandom_range(1) ? 2'b11 : 2'b00;
		return b;
	endfunction

	function automatic mfr_pkg::mfr_result_t status_word(input logic [2:0] st,
			input logic [7:0] len);
		mfr_pkg::mfr_result_t r;
		r.kind = mfr_pkg::KIND_STATUS;
		r.payload = 8'h00;
		r.status = st;
		r.length = len;
		return r;
	endfunction

	function automatic mfr_pkg::mfr_result_t payload_word(input logic [7:0] p);
		mfr_pkg::mfr_result_t r;
		r.kind = mfr_pkg::KIND_PAYLOAD;
		r.payload = p;
		r.status = mfr_pkg::ST_OK;
		r.length = 8'h00;
		return r;
	endfunction

	function automatic mfr_pkg::mfr_result_t close_frame(input logic [2:0] st,
			input logic [7:0] len);
		phase_q = PH_HUNT;
		hunt_cnt = 8'h00;
		return status_word(st, len);
	endfunction

	function automatic dir_row_t row(input logic [7:0] rx);
		return '{rx: rx, fixed: 1'b0, has: 1'b0, res: '0};
	endfunction

	function automatic dir_row_t row_exp(input logic [7:0] rx, input logic has,
			input mfr_pkg::mfr_result_t r);
		return '{rx: rx, fixed: 1'b1, has: has, res: r};
	endfunction

	// Advances the frame state by one received byte; returns 1 when the byte yields a result.
	function automatic logic frame_decode_step(input logic [7:0] b,
			output mfr_pkg::mfr_result_t r);
		logic [7:0] half;
		logic [7:0] full;
		half = unpack_half(b);
		full = {hi_half[3:0], 4'h0} + half;
		r = '0;
		case (phase_q)
			PH_HUNT: begin
				// The count is tested before validity, so a late valid byte still times out.
				hunt_cnt = hunt_cnt + 8'd1;
				if (hunt_cnt > hunt_limit_cfg) begin
					r = close_frame(mfr_pkg::ST_TIMEOUT, 8'h00);
					return 1'b1;
				end
				if (clean_pairs(b)) begin
					hi_half = half;
					phase_q = PH_DST_LO;
				end
			end
			PH_DST_LO: begin
				if (!clean_pairs(b)) begin
					r = close_frame(mfr_pkg::ST_CORRUPT, 8'h00);
					return 1'b1;
				end
				if (full != own_addr_cfg) begin
					r = close_frame(mfr_pkg::ST_DEST, 8'h00);
					return 1'b1;
				end
				run_sum = full;
				phase_q = PH_SRC_HI;
			end
			PH_SRC_HI, PH_LEN_HI, PH_PAY_HI, PH_SUM_HI: begin
				hi_half = half;
				phase_q = frame_phase_t'(phase_q + 4'd1);
			end
			PH_SRC_LO: begin
				if (full != peer_addr_cfg) begin
					r = close_frame(mfr_pkg::ST_SOURCE, 8'h00);
					return 1'b1;
				end
				run_sum = run_sum + full;
				phase_q = PH_LEN_HI;
			end
			PH_LEN_LO: begin
				run_sum = run_sum + full;
				frame_len = full;
				pay_cnt = 8'h00;
				phase_q = (full == 8'h00) ? PH_SUM_HI : PH_PAY_HI;
			end
			PH_PAY_LO: begin
				run_sum = run_sum + full;
				pay_cnt = pay_cnt + 8'd1;
				phase_q = (pay_cnt == frame_len) ? PH_SUM_HI : PH_PAY_HI;
				r = payload_word(full);
				return 1'b1;
			end
			PH_SUM_LO: begin
				if (full != run_sum)
					r = close_frame(mfr_pkg::ST_CHECKSUM, 8'h00);
				else
					r = close_frame(mfr_pkg::ST_OK, frame_len);
				return 1'b1;
			end
			default: begin
				phase_q = PH_HUNT;
				hunt_cnt = 8'h00;
			end
		endcase
		return 1'b0;
	endfunction

	// Offers one beat, after a random idle gap, and returns at the edge that takes it.
	task automatic offer_beat(input logic [7:0] b);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent++;
	endtask

	task automatic feed(input logic [7:0] b);
		mfr_pkg::mfr_result_t r;
		offer_beat(b);
		if (frame_decode_step(b, r))
			results_due.push_back(r);
	endtask

	task automatic feed_frame_byte(input logic [7:0] x);
		feed(enc_half(x[7:4]));
		feed(enc_half(x[3:0]));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			mfr_pkg::REG_OWN_ADDRESS: own_addr_cfg = v;
			mfr_pkg::REG_PEER_ADDRESS: peer_addr_cfg = v;
			default: hunt_limit_cfg = v;
		endcase
	endtask

	task automatic apply_setting(input logic [7:0] own, input logic [7:0] peer,
			input logic [7:0] limit);
		reg_write(mfr_pkg::REG_OWN_ADDRESS, own);
		reg_write(mfr_pkg::REG_PEER_ADDRESS, peer);
		reg_write(mfr_pkg::REG_HUNT_LIMIT, limit);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One frame with random content; a share of them is broken on purpose.
	task automatic random_frame(input logic big);
		int pick;
		logic [7:0] dst;
		logic [7:0] src;
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] hb;
		logic [7:0] lb;
		logic [7:0] full;
		while (phase_q != PH_HUNT)
			feed(8'($urandom_range(255)));
		pick = $urandom_range(99);
		dst = own_addr_cfg;
		src = peer_addr_cfg;
		if (pick < 6)
			dst = dst ^ (8'h01 << $urandom_range(7));
		else if (pick < 12)
			src = src ^ (8'h01 << $urandom_range(7));
		len = big ? 8'd32 : ($urandom_range(14) == 0 ? 8'h00 : 8'($urandom_range(1, 6)));
		// Junk ahead of the frame; with a small hunt limit it ends in a timeout.
		repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
			feed(bad_byte());
		feed(enc_half(dst[7:4]));
		if (pick >= 12 && pick < 18) begin
			feed(bad_byte());
			return;
		end
		feed(enc_half(dst[3:0]));
		if (dst != own_addr_cfg)
			return;
		feed_frame_byte(src);
		if (src != peer_addr_cfg)
			return;
		feed_frame_byte(len);
		sum = dst + src + len;
		for (int i = 0; i < len; i++) begin
			// Payload halves are not checked, so bad pairs decode with wraparound.
			if ($urandom_range(1)) begin
				hb = 8'($urandom_range(255));
				lb = 8'($urandom_range(255));
			end else begin
				full = 8'($urandom_range(255));
				hb = enc_half(full[7:4]);
				lb = enc_half(full[3:0]);
			end
			full = unpack_half(hb);
			full = {full[3:0], 4'h0} + unpack_half(lb);
			sum = sum + full;
			feed(hb);
			feed(lb);
		end
		if (pick >= 18 && pick < 26)
			sum = sum ^ (8'h01 << $urandom_range(7));
		feed_frame_byte(sum);
	endtask

	always @(posedge clk) begin : check_results
		mfr_pkg::mfr_result_t got;
		mfr_pkg::mfr_result_t want;
		if (out_valid && out_ready) begin
			got = {result_kind, payload_byte, end_status, received_length};
			if (results_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result kind=%0d payload=%02h status=%0d length=%0d",
						$time, got.kind, got.payload, got.status, got.length);
			end else begin
				want = results_due.pop_front();
				if (got.kind !== want.kind || got.payload !== want.payload
						|| got.status !== want.status || got.length !== want.length) begin
					errors++;
					if (errors <= 10)
						$display({"%0t: mismatch: expected kind=%0d payload=%02h status=%0d ",
							"length=%0d, got kind=%0d payload=%02h status=%0d length=%0d"},
							$time, want.kind, want.payload, want.status, want.length,
							got.kind, got.payload, got.status, got.length);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("manchester_frame_receiver_unit_tb: errors");
		$finish;
	end

	initial begin : stimulus
		dir_row_t             tab [28];
		setting_t             plan [6];
		mfr_pkg::mfr_result_t r;
		logic                 got_one;
		int                   stop_at;

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames run with a hunt limit of 1 and both addresses at zero.
		apply_setting(8'h00, 8'h00, 8'd1);
		tab = '{
			row_exp(8'h00, 1'b0, '0),
			row_exp(8'hFF, 1'b1, status_word(mfr_pkg::ST_TIMEOUT, 8'h00)),
			// Good frame: one payload byte of 0xFF, checksum wraps to 0x00.
			row(8'h55), row(8'h55), row(8'h55), row(8'h55), row(8'h55), row(8'h95),
			row(8'hAA), row_exp(8'hAA, 1'b1, payload_word(8'hFF)),
			row(8'h55), row_exp(8'h55, 1'b1, status_word(mfr_pkg::ST_OK, 8'h01)),
			row(8'h55), row_exp(8'h00, 1'b1, status_word(mfr_pkg::ST_CORRUPT, 8'h00)),
			row(8'hAA), row_exp(8'hAA, 1'b1, status_word(mfr_pkg::ST_DEST, 8'h00)),
			row(8'h55), row(8'h55), row(8'h55),
			row_exp(8'hAA, 1'b1, status_word(mfr_pkg::ST_SOURCE, 8'h00)),
			// Zero length, so the checksum follows the length at once.
			row(8'h55), row(8'h55), row(8'h55), row(8'h55), row(8'h55), row(8'h55),
			row(8'h55), row_exp(8'h95, 1'b1, status_word(mfr_pkg::ST_CHECKSUM, 8'h00))
		};
		foreach (tab[i]) begin
			offer_beat(tab[i].rx);
			got_one = frame_decode_step(tab[i].rx, r);
			if (tab[i].fixed) begin
				if (tab[i].has)
					results_due.push_back(tab[i].res);
			end else if (got_one) begin
				results_due.push_back(r);
			end
		end

		plan = '{
			'{8'($urandom_range(255)), 8'($urandom_range(255)),
				mfr_pkg::HUNT_LIMIT_RESET, 21, 100},
			'{8'h00, 8'hFF, 8'd1, 21, 100},
			'{8'hFF, 8'h00, 8'hFF, 0, 200},
			'{8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, 21, 40},
			'{8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(2, 254)), 21, 100},
			'{8'($urandom_range(255)), 8'($urandom_range(255)), 8'd3, 21, 100}
		};
		foreach (plan[p]) begin
			settle();
			apply_setting(plan[p].own, plan[p].peer, plan[p].limit);
			in_idle_pct = plan[p].idle;
			out_stall_pct = plan[p].idle;
			stop_at = beats_sent + plan[p].budget;
			if (plan[p].limit == 8'hFF) begin
				// The hunt count wraps past 255 here and never times out.
				repeat (260)
					feed(bad_byte());
				random_frame(1'b1);
			end
			while (beats_sent < stop_at) begin
				if ($urandom_range(99) < 75)
					random_frame(1'b0);
				else
					repeat ($urandom_range(1, 6))
						feed(8'($urandom_range(255)));
			end
		end

		settle();
		repeat (8)
			@(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("manchester_frame_receiver_unit_tb: clean");
		else
			$display("manchester_frame_receiver_unit_tb: errors");
		$finish;
	end

endmodule

/* manchester_frame_receiver_unit.f */
rtl/core/mfr_pkg.sv
rtl/core/manchester_frame_receiver_unit.sv
sim/manchester_frame_receiver_unit_tb.sv
